@@ rtl/pps_pkg.sv @@
`default_nettype none

package pps_pkg;

  // field widths
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned TIME_W  = 21;
  localparam int unsigned SUM_W   = 25;
  localparam int unsigned PID_W   = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  // one process table entry
  typedef struct packed {
    logic [FIELD_W-1:0] arr;
    logic [FIELD_W-1:0] bur;
    logic [FIELD_W-1:0] pri;
    logic [FIELD_W-1:0] rem;
  } proc_entry_t;

endpackage

`default_nettype wire

@@ rtl/preemptive_priority_scheduler.sv @@
// Operation: processes are loaded one after another. After the last process
//   the schedule runs in steps (a table scan through the process memory read
//   port, a decide state, a write-back state), at most about 3n steps, then
//   emits n records, each held until the sink accepts it.
// Throughput: one process set at a time; input is not taken until the last
//   record of the previous set has been accepted.
// Reset: asynchronous, active low; clears control state and counters. The
//   process and finish memories are not cleared and need no clearing pass.
`default_nettype none

module preemptive_priority_scheduler #(
  parameter int unsigned MAX_PROCS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // process load channel
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [pps_pkg::FIELD_W-1:0]      arrival_time_i,
  input  wire logic [pps_pkg::FIELD_W-1:0]      burst_time_i,
  input  wire logic [pps_pkg::FIELD_W-1:0]      priority_req_i,
  input  wire logic                             last_process_i,
  // result record channel
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [pps_pkg::PID_W-1:0]             process_id_o,
  output logic [pps_pkg::TIME_W-1:0]            wait_time_o,
  output logic [pps_pkg::TIME_W-1:0]            turnaround_time_o,
  output logic [pps_pkg::SUM_W-1:0]             total_wait_o,
  output logic [pps_pkg::SUM_W-1:0]             total_turnaround_o,
  output logic                                  last_record_o
);

  localparam int unsigned IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PROCS + 1);
  // latest completion is below (MAX_PROCS + 1) * 2^16
  localparam int unsigned TCK_RAW = $clog2((MAX_PROCS + 1) * (1 << pps_pkg::FIELD_W));
  localparam int unsigned TICK_W  = (TCK_RAW > pps_pkg::TIME_W) ? TCK_RAW : pps_pkg::TIME_W;

  localparam int unsigned FW = pps_pkg::FIELD_W;
  localparam int unsigned TW = pps_pkg::TIME_W;
  localparam int unsigned SW = pps_pkg::SUM_W;

  typedef enum logic [2:0] {
    S_LOAD,    // taking processes
    S_SCAN,    // walking the table for best eligible and next arrival
    S_DECIDE,  // idle jump or pick run length
    S_APPLY,   // advance time, write back remaining burst
    S_ORD,     // read entry for the next record
    S_OC1,     // turnaround
    S_OC2,     // wait time and running totals
    S_OSEND    // record waits for the sink
  } state_e;

  // ---------------------------------------------------------------------
  // Storage: process table and finish ticks, registered synchronous read
  // ---------------------------------------------------------------------
  pps_pkg::proc_entry_t proc_mem [MAX_PROCS];
  logic [TW-1:0]        fin_mem  [MAX_PROCS];

  logic                 pm_we;
  logic [IDX_W-1:0]     pm_waddr;
  pps_pkg::proc_entry_t pm_wdata;
  logic                 fm_we;
  logic [IDX_W-1:0]     fm_waddr;
  logic [TW-1:0]        fm_wdata;
  logic [IDX_W-1:0]     rd_addr;
  pps_pkg::proc_entry_t rd_pm_q;
  logic [TW-1:0]        rd_fm_q;

  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      proc_mem[pm_waddr] <= pm_wdata;
    end
    if (fm_we) begin
      fin_mem[fm_waddr] <= fm_wdata;
    end
    rd_pm_q <= proc_mem[rd_addr];
    rd_fm_q <= fin_mem[rd_addr];
  end

  // ---------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;          // loaded processes
  logic [CNT_W-1:0]     fin_cnt_q, fin_cnt_d;  // completed processes
  logic [TICK_W-1:0]    tick_q, tick_d;
  logic [CNT_W-1:0]     scan_q, scan_d;        // next table address to read
  logic                 pend_q, pend_d;        // read data in flight
  logic [IDX_W-1:0]     pend_idx_q, pend_idx_d;
  logic                 best_vld_q, best_vld_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  pps_pkg::proc_entry_t best_q, best_d;
  logic                 next_vld_q, next_vld_d;
  logic [FW-1:0]        next_arr_q, next_arr_d;
  logic [FW-1:0]        run_q, run_d;
  logic [CNT_W-1:0]     oidx_q, oidx_d;
  logic [TW-1:0]        tat_q, tat_d;
  logic [FW-1:0]        obur_q, obur_d;

  logic                 out_valid_q, out_valid_d;
  logic [pps_pkg::PID_W-1:0] pid_q, pid_d;
  logic [TW-1:0]        owait_q, owait_d;
  logic [TW-1:0]        otat_q, otat_d;
  logic [SW-1:0]        tw_q, tw_d;
  logic [SW-1:0]        tt_q, tt_d;
  logic                 olast_q, olast_d;

  // scratch values
  logic                 in_acc;
  logic [FW-1:0]        bur_fix;
  logic                 issue;
  logic [FW-1:0]        gap;
  logic [TICK_W-1:0]    tick_new;
  logic [FW-1:0]        rem_new;
  logic [TW-1:0]        fin_sat;
  logic [TW-1:0]        wait_v;
  logic [SW:0]          tw_sum;
  logic [SW:0]          tt_sum;

  assign in_ready_o = (state_q == S_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    fin_cnt_d  = fin_cnt_q;
    tick_d     = tick_q;
    scan_d     = scan_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    best_vld_d = best_vld_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    next_vld_d = next_vld_q;
    next_arr_d = next_arr_q;
    run_d      = run_q;
    oidx_d     = oidx_q;
    tat_d      = tat_q;
    obur_d     = obur_q;
    out_valid_d = out_valid_q;
    pid_d      = pid_q;
    owait_d    = owait_q;
    otat_d     = otat_q;
    tw_d       = tw_q;
    tt_d       = tt_q;
    olast_d    = olast_q;

    pm_we    = 1'b0;
    pm_waddr = cnt_q[IDX_W-1:0];
    pm_wdata = '0;
    fm_we    = 1'b0;
    fm_waddr = best_idx_q;
    fm_wdata = '0;
    rd_addr  = scan_q[IDX_W-1:0];

    bur_fix  = (burst_time_i == '0) ? FW'(1) : burst_time_i;
    issue    = (scan_q < cnt_q);
    gap      = next_arr_q - tick_q[FW-1:0];
    tick_new = tick_q + TICK_W'(run_q);
    rem_new  = best_q.rem - run_q;
    fin_sat  = (tick_new > TICK_W'(pps_pkg::TIME_MAX)) ? pps_pkg::TIME_MAX
                                                        : tick_new[TW-1:0];
    wait_v   = (tat_q > TW'(obur_q)) ? (tat_q - TW'(obur_q)) : '0;
    tw_sum   = {1'b0, tw_q} + (SW + 1)'(wait_v);
    tt_sum   = {1'b0, tt_q} + (SW + 1)'(tat_q);

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_q < CNT_W'(MAX_PROCS)) begin
            pm_we    = 1'b1;
            pm_wdata = '{arr: arrival_time_i, bur: bur_fix,
                         pri: priority_req_i, rem: bur_fix};
            cnt_d    = cnt_q + 1'b1;
          end
          if (last_process_i) begin
            tick_d     = '0;
            fin_cnt_d  = '0;
            scan_d     = '0;
            best_vld_d = 1'b0;
            next_vld_d = 1'b0;
            tw_d       = '0;
            tt_d       = '0;
            state_d    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (issue) begin
          scan_d     = scan_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = scan_q[IDX_W-1:0];
        end
        // finished entries hold zero remaining and are skipped
        if (pend_q && (rd_pm_q.rem != '0)) begin
          if (TICK_W'(rd_pm_q.arr) <= tick_q) begin
            // strict compare keeps the lowest index on a tie
            if (!best_vld_q || (rd_pm_q.pri < best_q.pri)) begin
              best_vld_d = 1'b1;
              best_idx_d = pend_idx_q;
              best_d     = rd_pm_q;
            end
          end else if (!next_vld_q || (rd_pm_q.arr < next_arr_q)) begin
            next_vld_d = 1'b1;
            next_arr_d = rd_pm_q.arr;
          end
        end
        if (!issue) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (!best_vld_q) begin
          if (next_vld_q) begin
            // idle gap: jump to the next arrival and rescan
            tick_d     = TICK_W'(next_arr_q);
            scan_d     = '0;
            best_vld_d = 1'b0;
            next_vld_d = 1'b0;
            state_d    = S_SCAN;
          end else begin
            oidx_d  = '0;
            state_d = S_ORD;
          end
        end else begin
          // run until completion or the next arrival, whichever comes first
          run_d   = (next_vld_q && (gap < best_q.rem)) ? gap : best_q.rem;
          state_d = S_APPLY;
        end
      end

      S_APPLY: begin
        tick_d   = tick_new;
        pm_we    = 1'b1;
        pm_waddr = best_idx_q;
        pm_wdata = '{arr: best_q.arr, bur: best_q.bur, pri: best_q.pri, rem: rem_new};
        scan_d     = '0;
        best_vld_d = 1'b0;
        next_vld_d = 1'b0;
        state_d    = S_SCAN;
        if (rem_new == '0) begin
          fm_we     = 1'b1;
          fm_wdata  = fin_sat;
          fin_cnt_d = fin_cnt_q + 1'b1;
          if ((fin_cnt_q + 1'b1) == cnt_q) begin
            oidx_d  = '0;
            state_d = S_ORD;
          end
        end
      end

      S_ORD: begin
        rd_addr = oidx_q[IDX_W-1:0];
        state_d = S_OC1;
      end

      S_OC1: begin
        tat_d   = (rd_fm_q > TW'(rd_pm_q.arr)) ? (rd_fm_q - TW'(rd_pm_q.arr)) : '0;
        obur_d  = rd_pm_q.bur;
        state_d = S_OC2;
      end

      S_OC2: begin
        owait_d     = wait_v;
        otat_d      = tat_q;
        tw_d        = tw_sum[SW] ? pps_pkg::SUM_MAX : tw_sum[SW-1:0];
        tt_d        = tt_sum[SW] ? pps_pkg::SUM_MAX : tt_sum[SW-1:0];
        pid_d       = pps_pkg::PID_W'(oidx_q);
        olast_d     = ((oidx_q + 1'b1) == cnt_q);
        out_valid_d = 1'b1;
        state_d     = S_OSEND;
      end

      S_OSEND: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (olast_q) begin
            cnt_d     = '0;
            fin_cnt_d = '0;
            tick_d    = '0;
            state_d   = S_LOAD;
          end else begin
            oidx_d  = oidx_q + 1'b1;
            state_d = S_ORD;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      fin_cnt_q   <= '0;
      tick_q      <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      best_vld_q  <= 1'b0;
      next_vld_q  <= 1'b0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
      olast_q     <= 1'b0;
      tw_q        <= '0;
      tt_q        <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fin_cnt_q   <= fin_cnt_d;
      tick_q      <= tick_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      best_vld_q  <= best_vld_d;
      next_vld_q  <= next_vld_d;
      oidx_q      <= oidx_d;
      out_valid_q <= out_valid_d;
      olast_q     <= olast_d;
      tw_q        <= tw_d;
      tt_q        <= tt_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    next_arr_q <= next_arr_d;
    run_q      <= run_d;
    tat_q      <= tat_d;
    obur_q     <= obur_d;
    pid_q      <= pid_d;
    owait_q    <= owait_d;
    otat_q     <= otat_d;
  end

  assign out_valid_o        = out_valid_q;
  assign process_id_o       = pid_q;
  assign wait_time_o        = owait_q;
  assign turnaround_time_o  = otat_q;
  assign total_wait_o       = tw_q;
  assign total_turnaround_o = tt_q;
  assign last_record_o      = olast_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("load and record phases overlap");

  a_fin_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_cnt_q <= cnt_q)
    else $error("more completions than loaded processes");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_PROCS))
    else $error("process count beyond table depth");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_process_i) |=> !in_ready_o)
    else $error("last process did not start the schedule");

  a_set_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_record_o) |=> (in_ready_o && !out_valid_o))
    else $error("block did not return to loading after the last record");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned FIELD_W = pps_pkg::FIELD_W;
  localparam int unsigned TIME_W  = pps_pkg::TIME_W;
  localparam int unsigned SUM_W   = pps_pkg::SUM_W;
  localparam int unsigned PID_W   = pps_pkg::PID_W;
  localparam logic [TIME_W-1:0] TIME_MAX = pps_pkg::TIME_MAX;
  localparam logic [SUM_W-1:0]  SUM_MAX  = pps_pkg::SUM_MAX;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 300;
  // Worst set: 16 loads, ~48 schedule steps, 16 records, plus stalls.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES = 800;

  // One process offered on the load channel.
  typedef struct {
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] prio;
    logic               last;
  } proc_item_t;

  // One result record as the block should emit it.
  typedef struct {
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] wait_tk;
    logic [TIME_W-1:0] tat_tk;
    logic [SUM_W-1:0]  wait_total;
    logic [SUM_W-1:0]  tat_total;
    logic              last;
  } sched_record_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FIELD_W-1:0] in_arrival = '0;
  logic [FIELD_W-1:0] in_burst = '0;
  logic [FIELD_W-1:0] in_prio = '0;
  logic               in_last = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [PID_W-1:0]   out_pid;
  logic [TIME_W-1:0]  out_wait;
  logic [TIME_W-1:0]  out_tat;
  logic [SUM_W-1:0]   out_wait_total;
  logic [SUM_W-1:0]   out_tat_total;
  logic               out_last;

  preemptive_priority_scheduler #(
    .MAX_PROCS(TABLE_DEPTH)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .arrival_time_i    (in_arrival),
    .burst_time_i      (in_burst),
    .priority_req_i    (in_prio),
    .last_process_i    (in_last),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .process_id_o      (out_pid),
    .wait_time_o       (out_wait),
    .turnaround_time_o (out_tat),
    .total_wait_o      (out_wait_total),
    .total_turnaround_o(out_tat_total),
    .last_record_o     (out_last)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Scheduler predictor: its own process table, filled per accepted transaction.
  // ---------------------------------------------------------------------------
  int unsigned   tbl_arrival[TABLE_DEPTH];
  int unsigned   tbl_burst[TABLE_DEPTH];
  int unsigned   tbl_left[TABLE_DEPTH];
  int unsigned   tbl_prio[TABLE_DEPTH];
  int unsigned   tbl_finish[TABLE_DEPTH];
  int unsigned   tbl_count = 0;

  proc_item_t    pending_procs[$];
  sched_record_t expected_records[$];

  int unsigned   mismatches = 0;
  int unsigned   items_accepted = 0;
  int unsigned   sets_scheduled = 0;
  int unsigned   records_checked = 0;
  int unsigned   procs_dropped = 0;
  int unsigned   cycle_count = 0;

  function automatic int unsigned clip_time(longint unsigned v);
    return (v > longint'(TIME_MAX)) ? int'(TIME_MAX) : int'(v);
  endfunction

  function automatic int unsigned clip_sum(longint unsigned v);
    return (v > longint'(SUM_MAX)) ? int'(SUM_MAX) : int'(v);
  endfunction

  // Event-driven replay of the schedule: jump over idle stretches, and let the
  // chosen process run until it completes or the next arrival can preempt it.
  task automatic schedule_table();
    longint unsigned now;
    longint unsigned next_arr;
    longint unsigned slice;
    longint unsigned wait_run;
    longint unsigned tat_run;
    int              best;
    bit              have_next;
    int unsigned     done_n;
    int unsigned     tat;
    int unsigned     wt;
    sched_record_t   rec;
    now = 0;
    done_n = 0;
    while (done_n < tbl_count) begin
      best = -1;
      have_next = 1'b0;
      next_arr = 0;
      for (int i = 0; i < int'(tbl_count); i++) begin
        if (tbl_left[i] == 0) continue;
        if (longint'(tbl_arrival[i]) <= now) begin
          if (best < 0 || tbl_prio[i] < tbl_prio[best]) best = i;
        end else if (!have_next || longint'(tbl_arrival[i]) < next_arr) begin
          have_next = 1'b1;
          next_arr = 64'(tbl_arrival[i]);
        end
      end
      if (best < 0) begin
        if (!have_next) break;
        now = next_arr;   // idle gap
        continue;
      end
      slice = 64'(tbl_left[best]);
      if (have_next && (next_arr - now) < slice) slice = next_arr - now;
      now += slice;
      tbl_left[best] -= 32'(slice);
      if (tbl_left[best] == 0) begin
        tbl_finish[best] = clip_time(now);
        done_n++;
      end
    end
    // records come out in load order with running totals
    wait_run = 0;
    tat_run = 0;
    for (int unsigned i = 0; i < tbl_count; i++) begin
      tat = (tbl_finish[i] > tbl_arrival[i]) ?
            clip_time(longint'(tbl_finish[i] - tbl_arrival[i])) : 0;
      wt = (tat > tbl_burst[i]) ? tat - tbl_burst[i] : 0;
      wait_run = 64'(clip_sum(wait_run + 64'(wt)));
      tat_run = 64'(clip_sum(tat_run + 64'(tat)));
      rec.pid = PID_W'(i);
      rec.wait_tk = TIME_W'(wt);
      rec.tat_tk = TIME_W'(tat);
      rec.wait_total = SUM_W'(wait_run);
      rec.tat_total = SUM_W'(tat_run);
      rec.last = (i + 1 == tbl_count);
      expected_records.push_back(rec);
    end
    tbl_count = 0;
    sets_scheduled++;
  endtask

  task automatic load_process(proc_item_t it);
    int unsigned bur;
    bur = (it.burst == 0) ? 1 : 32'(it.burst);   // zero burst counts as one tick
    if (tbl_count < TABLE_DEPTH) begin
      tbl_arrival[tbl_count] = 32'(it.arrival);
      tbl_burst[tbl_count] = bur;
      tbl_left[tbl_count] = bur;
      tbl_prio[tbl_count] = 32'(it.prio);
      tbl_finish[tbl_count] = 0;
      tbl_count++;
    end else begin
      procs_dropped++;   // table full: process is lost, a last mark still counts
    end
    if (it.last) schedule_table();
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of back-to-back transactions separated by random gaps.
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    proc_item_t it;
    proc_item_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_arrival <= '0;
      in_burst <= '0;
      in_prio <= '0;
      in_last <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        it.arrival = in_arrival;
        it.burst = in_burst;
        it.prio = in_prio;
        it.last = in_last;
        load_process(it);
        items_accepted++;
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_procs.size() != 0) begin
        nxt = pending_procs.pop_front();
        in_valid <= 1'b1;
        in_arrival <= nxt.arrival;
        in_burst <= nxt.burst;
        in_prio <= nxt.prio;
        in_last <= nxt.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall patterns; one long hold-off keeps a record waiting
  // so the block keeps its load channel closed.
  // ---------------------------------------------------------------------------
  int unsigned ready_mode = 0;
  int unsigned hold_count = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && out_valid && cycle_count > 2000) begin
        hold_count <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_count != 0) begin
        hold_count <= hold_count - 1;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (cycle_count % 128 == 0) ready_mode = $urandom_range(0, 2);
      if (hold_count != 0) begin
        out_ready <= 1'b0;
      end else begin
        case (ready_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: every accepted record is checked against the oldest expectation.
  always @(posedge clk_i) begin
    sched_record_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        report_mismatch("unexpected record, pid", 64'(out_pid), 0);
      end else begin
        want = expected_records.pop_front();
        records_checked++;
        if (out_pid !== want.pid)
          report_mismatch("process_id", 64'(out_pid), 64'(want.pid));
        if (out_wait !== want.wait_tk)
          report_mismatch("wait_time", 64'(out_wait), 64'(want.wait_tk));
        if (out_tat !== want.tat_tk)
          report_mismatch("turnaround_time", 64'(out_tat), 64'(want.tat_tk));
        if (out_wait_total !== want.wait_total)
          report_mismatch("total_wait", 64'(out_wait_total), 64'(want.wait_total));
        if (out_tat_total !== want.tat_total)
          report_mismatch("total_turnaround", 64'(out_tat_total), 64'(want.tat_total));
        if (out_last !== want.last)
          report_mismatch("last_record", 64'(out_last), 64'(want.last));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic proc_item_t make_proc(int unsigned arr, int unsigned bur,
                                           int unsigned pri, bit last);
    proc_item_t it;
    it.arrival = FIELD_W'(arr);
    it.burst = FIELD_W'(bur);
    it.prio = FIELD_W'(pri);
    it.last = last;
    return it;
  endfunction

  function automatic int unsigned rand_field(bit narrow, int unsigned narrow_max);
    return narrow ? $urandom_range(0, narrow_max) : $urandom_range(0, 65535);
  endfunction

  initial begin
    int unsigned queued;
    int unsigned set_len;
    int unsigned sel;
    int unsigned arr;
    bit          narrow_arr;
    bit          narrow_bur;
    bit          narrow_pri;

    // single process at the top of every field: long idle stretch, max burst
    pending_procs.push_back(make_proc(65535, 65535, 65535, 1'b1));
    // zero burst, priority tie at tick 0, then an idle gap before the third
    pending_procs.push_back(make_proc(0, 0, 0, 1'b0));
    pending_procs.push_back(make_proc(0, 1, 0, 1'b0));
    pending_procs.push_back(make_proc(10, 65535, 65535, 1'b1));
    // full table with staggered arrivals, each newcomer preempting; the extra
    // process is dropped but its last mark still starts the schedule
    for (int i = 0; i < int'(TABLE_DEPTH); i++)
      pending_procs.push_back(make_proc(i * 3, 10, 15 - i, 1'b0));
    pending_procs.push_back(make_proc(1, 1, 0, 1'b1));

    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) set_len = $urandom_range(1, 6);
      else if (sel < 9) set_len = $urandom_range(7, TABLE_DEPTH);
      else set_len = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 3);   // overfill
      narrow_arr = ($urandom_range(0, 3) != 0);
      narrow_bur = ($urandom_range(0, 3) != 0);
      narrow_pri = ($urandom_range(0, 2) != 0);
      for (int unsigned k = 0; k < set_len; k++) begin
        arr = ($urandom_range(0, 15) == 0) ? $urandom_range(65400, 65535)
                                           : rand_field(narrow_arr, 40);
        pending_procs.push_back(make_proc(arr, rand_field(narrow_bur, 12),
                                          rand_field(narrow_pri, 3), k + 1 == set_len));
      end
      queued += set_len;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_procs.size() != 0 || in_valid || expected_records.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("scheduled %0d process sets from %0d transactions (%0d dropped on a full table)",
             sets_scheduled, items_accepted, procs_dropped);
    $display("checked %0d result records in %0d cycles", records_checked, cycle_count);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
